// ===== rtl/tlvd_pkg.sv =====
// Shared types and codes for the TLV packet deframer.
package tlvd_pkg;

   // byte classes
   localparam logic [2:0] CLS_APP    = 3'd0;
   localparam logic [2:0] CLS_CODE   = 3'd1;
   localparam logic [2:0] CLS_PLEN   = 3'd2;
   localparam logic [2:0] CLS_ATYPE  = 3'd3;
   localparam logic [2:0] CLS_ALEN   = 3'd4;
   localparam logic [2:0] CLS_VALUE  = 3'd5;
   localparam logic [2:0] CLS_IGNORE = 3'd6;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_PKT_SHORT  = 2'd1;
   localparam logic [1:0] ERR_ATTR_SHORT = 2'd2;
   localparam logic [1:0] ERR_OVERRUN    = 2'd3;

   localparam logic [15:0] PKT_HDR_LEN  = 16'd5;
   localparam logic [15:0] ATTR_HDR_LEN = 16'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [15:0] application_id;
      logic [7:0]  packet_code;
      logic [15:0] packet_length;
      logic [7:0]  attr_type;
      logic [15:0] attr_length;
      logic [7:0]  value_byte;
      logic [15:0] value_index;
      logic        attr_done;
      logic        packet_done;
      logic [1:0]  parse_error;
   } rsp_type;

   // classified byte, front to back
   typedef struct packed {
      logic        start;
      logic [2:0]  cls;
      logic        hi;      // high byte of a 16-bit field
      logic [7:0]  data;
      logic [15:0] vidx;
      logic        adone;
      logic        pdone;
      logic [1:0]  err;
   } cmd_type;

endpackage

// ===== rtl/tlv_packet_deframer_core.sv =====
// TLV packet deframer: top level tying parser front end, queue and result back end.
//
// One packet byte enters per transfer on the req_ channel; frame_start marks the
// first header byte and restarts parsing at any point. Every byte produces exactly
// one result on the rsp_ channel, in order, carrying its class, the header and
// attribute fields decoded so far, value index, end-of-attribute/packet marks and
// the packet's error code.
// Throughput is one byte per cycle while req_stall is low: the parser updates
// its counters as each byte is accepted. After its req_ transfer a byte's result
// is registered in a queue entry, then in the result register, before its rsp_
// transfer; it waits longer while the two-entry queue holds earlier bytes.
// When the receiver raises rsp_stall, the result register holds and the queue
// keeps taking bytes; req_stall rises once both queue entries are occupied.
// req_stall depends only on queue occupancy, never on req_valid.
// Synchronous reset returns the parser to idle (bytes ignored until a frame
// start), clears all decoded fields and empties the queue and result register.
module tlv_packet_deframer_core
   import tlvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    accept;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   cmd_type front_cmd;
   cmd_type q_head;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   tlvd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cmd    (front_cmd)
   );

   tlvd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   tlvd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_not_empty),
      .cmd         (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/tlvd_front.sv =====
// Front end: packet/attribute parser that classifies each byte into a command.
module tlvd_front
   import tlvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output cmd_type cmd
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_ATYPE  = 3'd2;
   localparam logic [2:0] PH_ALENHI = 3'd3;
   localparam logic [2:0] PH_ALENLO = 3'd4;
   localparam logic [2:0] PH_VALUE  = 3'd5;
   localparam logic [2:0] PH_SKIP   = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic [15:0] prem_ff, prem_in;
   logic [15:0] arem_ff, arem_in;
   logic [15:0] vpos_ff, vpos_in;
   logic [1:0]  err_ff, err_in;
   logic [7:0]  plen_hi_ff, plen_hi_in;
   logic [7:0]  alen_hi_ff, alen_hi_in;

   logic [2:0]  ph;
   logic [15:0] prem, prem_dec, arem_dec, plen, alen;
   logic [16:0] avail;

   always_comb begin
      // a frame start restarts the parser on this byte
      ph         = req.frame_start ? PH_HEADER : phase_ff;
      hcnt_in    = req.frame_start ? 3'd0 : hcnt_ff;
      prem       = req.frame_start ? 16'd0 : prem_ff;
      arem_in    = req.frame_start ? 16'd0 : arem_ff;
      vpos_in    = req.frame_start ? 16'd0 : vpos_ff;
      err_in     = req.frame_start ? ERR_NONE : err_ff;
      plen_hi_in = req.frame_start ? 8'd0 : plen_hi_ff;
      alen_hi_in = req.frame_start ? 8'd0 : alen_hi_ff;
      prem_in    = prem;
      phase_in   = ph;
      prem_dec   = prem - 16'd1;
      arem_dec   = arem_in - 16'd1;
      plen       = {plen_hi_in, req.data_byte};
      alen       = {alen_hi_in, req.data_byte};
      avail      = {1'b0, prem} + 17'd2;

      cmd       = '0;
      cmd.start = req.frame_start;
      cmd.data  = req.data_byte;
      cmd.cls   = CLS_IGNORE;

      case (ph)
         PH_HEADER: begin
            case (hcnt_in)
               3'd0: begin
                  cmd.cls = CLS_APP;
                  cmd.hi  = 1'b1;
               end
               3'd1: cmd.cls = CLS_APP;
               3'd2: cmd.cls = CLS_CODE;
               3'd3: begin
                  cmd.cls    = CLS_PLEN;
                  cmd.hi     = 1'b1;
                  plen_hi_in = req.data_byte;
               end
               default: begin
                  cmd.cls = CLS_PLEN;
                  if (plen < PKT_HDR_LEN) begin
                     err_in    = ERR_PKT_SHORT;
                     cmd.pdone = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     prem_in = plen - PKT_HDR_LEN;
                     if (plen == PKT_HDR_LEN) begin
                        cmd.pdone = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_ATYPE;
                     end
                  end
               end
            endcase
            hcnt_in = hcnt_in + 3'd1;
         end
         PH_ATYPE: begin
            cmd.cls = CLS_ATYPE;
            vpos_in = 16'd0;
            prem_in = prem_dec;
            if (prem_dec == 16'd0) begin
               err_in    = ERR_OVERRUN;
               cmd.pdone = 1'b1;
               phase_in  = PH_IDLE;
            end else begin
               phase_in = PH_ALENHI;
            end
         end
         PH_ALENHI: begin
            cmd.cls    = CLS_ALEN;
            cmd.hi     = 1'b1;
            alen_hi_in = req.data_byte;
            prem_in    = prem_dec;
            if (prem_dec == 16'd0) begin
               err_in    = ERR_OVERRUN;
               cmd.pdone = 1'b1;
               phase_in  = PH_IDLE;
            end else begin
               phase_in = PH_ALENLO;
            end
         end
         PH_ALENLO: begin
            cmd.cls = CLS_ALEN;
            prem_in = prem_dec;
            if (alen < ATTR_HDR_LEN || {1'b0, alen} > avail) begin
               err_in = (alen < ATTR_HDR_LEN) ? ERR_ATTR_SHORT : ERR_OVERRUN;
               if (prem_dec == 16'd0) begin
                  cmd.pdone = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  phase_in = PH_SKIP;
               end
            end else if (alen == ATTR_HDR_LEN) begin
               cmd.adone = 1'b1;
               if (prem_dec == 16'd0) begin
                  cmd.pdone = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  phase_in = PH_ATYPE;
               end
            end else begin
               arem_in  = alen - ATTR_HDR_LEN;
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            cmd.cls  = CLS_VALUE;
            cmd.vidx = vpos_in;
            vpos_in  = vpos_in + 16'd1;
            arem_in  = arem_dec;
            prem_in  = prem_dec;
            if (arem_dec == 16'd0) begin
               cmd.adone = 1'b1;
               if (prem_dec == 16'd0) begin
                  cmd.pdone = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  phase_in = PH_ATYPE;
               end
            end
         end
         PH_SKIP: begin
            prem_in = prem_dec;
            if (prem_dec == 16'd0) begin
               cmd.pdone = 1'b1;
               phase_in  = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      cmd.err = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hcnt_ff    <= 3'd0;
         prem_ff    <= 16'd0;
         arem_ff    <= 16'd0;
         vpos_ff    <= 16'd0;
         err_ff     <= ERR_NONE;
         plen_hi_ff <= 8'd0;
         alen_hi_ff <= 8'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hcnt_ff    <= hcnt_in;
         prem_ff    <= prem_in;
         arem_ff    <= arem_in;
         vpos_ff    <= vpos_in;
         err_ff     <= err_in;
         plen_hi_ff <= plen_hi_in;
         alen_hi_ff <= alen_hi_in;
      end
   end

endmodule

// ===== rtl/tlvd_queue.sv =====
// Two-entry command queue between parser front end and result back end.
module tlvd_queue
   import tlvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/tlvd_back.sv =====
// Back end: keeps decoded header/attribute fields and drives the result register.
module tlvd_back
   import tlvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic [15:0] app_ff, app_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] plen_ff, plen_in;
   logic [7:0]  atype_ff, atype_in;
   logic [15:0] alen_ff, alen_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   assign pop         = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      app_in   = cmd.start ? 16'd0 : app_ff;
      code_in  = cmd.start ? 8'd0 : code_ff;
      plen_in  = cmd.start ? 16'd0 : plen_ff;
      atype_in = cmd.start ? 8'd0 : atype_ff;
      alen_in  = cmd.start ? 16'd0 : alen_ff;

      case (cmd.cls)
         CLS_APP: begin
            if (cmd.hi) app_in = {cmd.data, 8'd0};
            else        app_in[7:0] = cmd.data;
         end
         CLS_CODE: code_in = cmd.data;
         CLS_PLEN: begin
            if (cmd.hi) plen_in = {cmd.data, 8'd0};
            else        plen_in[7:0] = cmd.data;
         end
         CLS_ATYPE: begin
            atype_in = cmd.data;
            alen_in  = 16'd0;
         end
         CLS_ALEN: begin
            if (cmd.hi) alen_in = {cmd.data, 8'd0};
            else        alen_in[7:0] = cmd.data;
         end
         default: ;
      endcase

      rsp_in.byte_class     = cmd.cls;
      rsp_in.application_id = app_in;
      rsp_in.packet_code    = code_in;
      rsp_in.packet_length  = plen_in;
      rsp_in.attr_type      = atype_in;
      rsp_in.attr_length    = alen_in;
      rsp_in.value_byte     = (cmd.cls == CLS_VALUE) ? cmd.data : 8'd0;
      rsp_in.value_index    = cmd.vidx;
      rsp_in.attr_done      = cmd.adone;
      rsp_in.packet_done    = cmd.pdone;
      rsp_in.parse_error    = cmd.err;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         app_ff       <= 16'd0;
         code_ff      <= 8'd0;
         plen_ff      <= 16'd0;
         atype_ff     <= 8'd0;
         alen_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            app_ff   <= app_in;
            code_ff  <= code_in;
            plen_ff  <= plen_in;
            atype_ff <= atype_in;
            alen_ff  <= alen_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== verif/tlv_packet_deframer_core_test.sv =====
// Self-checking testbench for the TLV packet deframer core, with a byte-level parse predictor.
module tlv_packet_deframer_core_test
   import tlvd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 1870;
   localparam int unsigned DRAIN_EVERY  = 400;
   localparam int unsigned IDLE_LIMIT   = 2000;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_HEADER    = 3'd1;
   localparam logic [2:0] ST_ATTR_TYPE = 3'd2;
   localparam logic [2:0] ST_ALEN_HI   = 3'd3;
   localparam logic [2:0] ST_ALEN_LO   = 3'd4;
   localparam logic [2:0] ST_VALUE     = 3'd5;
   localparam logic [2:0] ST_SKIP      = 3'd6;

   // directed byte; where pinned, class, error and packet end are given by hand
   typedef struct packed {
      req_type    item;
      logic       pinned;
      logic [2:0] cls;
      logic [1:0] err;
      logic       done;
   } plan_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // parse state of the predictor
   logic [2:0]   pstate = ST_IDLE;
   logic [2:0]   hdr_count = '0;
   logic [15:0]  pkt_left = '0;
   logic [15:0]  val_left = '0;
   logic [15:0]  cur_app = '0;
   logic [7:0]   cur_code = '0;
   logic [15:0]  cur_plen = '0;
   logic [7:0]   cur_atype = '0;
   logic [15:0]  cur_alen = '0;
   logic [15:0]  val_pos = '0;
   logic [1:0]   err_flag = ERR_NONE;

   rsp_type     classified_q[$];
   rsp_type     oldest;
   req_type     frame_q[$];
   int unsigned failures = 0;
   int unsigned idle_cycles = 0;
   bit          sender_gappy = 1'b1;

   plan_row_type script [29] = '{
      '{'{8'hFF, 1'b0}, 1'b1, CLS_IGNORE, ERR_NONE, 1'b0},
      // packet length under the header size
      '{'{8'h00, 1'b1}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h04, 1'b0}, 1'b1, CLS_PLEN, ERR_PKT_SHORT, 1'b1},
      // header-only packet, all-ones application id and code
      '{'{8'hFF, 1'b1}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'hFF, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'hFF, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h05, 1'b0}, 1'b1, CLS_PLEN, ERR_NONE, 1'b1},
      // one value byte, then the next attribute header runs off the packet end
      '{'{8'h80, 1'b1}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h01, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h5A, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h0A, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h01, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h04, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'hAA, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h02, 1'b0}, 1'b1, CLS_ATYPE, ERR_OVERRUN, 1'b1},
      // attribute length under its header size; left mid-skip for a restart
      '{'{8'h12, 1'b1}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h34, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h56, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h09, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h7F, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h00, 1'b0}, 1'b0, CLS_APP, ERR_NONE, 1'b0},
      '{'{8'h02, 1'b0}, 1'b1, CLS_ALEN, ERR_ATTR_SHORT, 1'b0}
   };

   tlv_packet_deframer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // attribute or packet boundary: returns 1 when the packet is used up
   function automatic logic close_segment();
      if (pkt_left == 16'd0) begin
         pstate = ST_IDLE;
         return 1'b1;
      end
      pstate = ST_ATTR_TYPE;
      return 1'b0;
   endfunction

   function automatic rsp_type classify_byte(req_type r);
      rsp_type     res;
      logic [16:0] room;
      res = '0;
      res.byte_class = CLS_IGNORE;
      if (r.frame_start) begin
         pstate    = ST_HEADER;
         hdr_count = '0;
         pkt_left  = '0;
         val_left  = '0;
         cur_app   = '0;
         cur_code  = '0;
         cur_plen  = '0;
         cur_atype = '0;
         cur_alen  = '0;
         val_pos   = '0;
         err_flag  = ERR_NONE;
      end
      case (pstate)
         ST_HEADER: begin
            case (hdr_count)
               3'd0: begin
                  res.byte_class = CLS_APP;
                  cur_app = {r.data_byte, 8'h00};
               end
               3'd1: begin
                  res.byte_class = CLS_APP;
                  cur_app = cur_app | {8'h00, r.data_byte};
               end
               3'd2: begin
                  res.byte_class = CLS_CODE;
                  cur_code = r.data_byte;
               end
               3'd3: begin
                  res.byte_class = CLS_PLEN;
                  cur_plen = {r.data_byte, 8'h00};
               end
               default: begin
                  res.byte_class = CLS_PLEN;
                  cur_plen = cur_plen | {8'h00, r.data_byte};
                  if (cur_plen < PKT_HDR_LEN) begin
                     err_flag = ERR_PKT_SHORT;
                     res.packet_done = 1'b1;
                     pstate = ST_IDLE;
                  end else begin
                     pkt_left = cur_plen - PKT_HDR_LEN;
                     res.packet_done = close_segment();
                  end
               end
            endcase
            hdr_count = hdr_count + 3'd1;
         end
         ST_ATTR_TYPE, ST_ALEN_HI: begin
            if (pstate == ST_ATTR_TYPE) begin
               res.byte_class = CLS_ATYPE;
               cur_atype = r.data_byte;
               cur_alen  = '0;
               val_pos   = '0;
            end else begin
               res.byte_class = CLS_ALEN;
               cur_alen = {r.data_byte, 8'h00};
            end
            pkt_left = pkt_left - 16'd1;
            if (pkt_left == 16'd0) begin
               // attribute header cut by the packet end
               err_flag = ERR_OVERRUN;
               res.packet_done = 1'b1;
               pstate = ST_IDLE;
            end else begin
               pstate = (pstate == ST_ATTR_TYPE) ? ST_ALEN_HI : ST_ALEN_LO;
            end
         end
         ST_ALEN_LO: begin
            room = {1'b0, pkt_left} + 17'd2;
            res.byte_class = CLS_ALEN;
            cur_alen = cur_alen | {8'h00, r.data_byte};
            pkt_left = pkt_left - 16'd1;
            if (cur_alen < ATTR_HDR_LEN || {1'b0, cur_alen} > room) begin
               err_flag = (cur_alen < ATTR_HDR_LEN) ? ERR_ATTR_SHORT : ERR_OVERRUN;
               if (pkt_left == 16'd0) begin
                  res.packet_done = 1'b1;
                  pstate = ST_IDLE;
               end else begin
                  pstate = ST_SKIP;
               end
            end else if (cur_alen == ATTR_HDR_LEN) begin
               res.attr_done = 1'b1;
               res.packet_done = close_segment();
            end else begin
               val_left = cur_alen - ATTR_HDR_LEN;
               pstate = ST_VALUE;
            end
         end
         ST_VALUE: begin
            res.byte_class  = CLS_VALUE;
            res.value_byte  = r.data_byte;
            res.value_index = val_pos;
            val_pos  = val_pos + 16'd1;
            val_left = val_left - 16'd1;
            pkt_left = pkt_left - 16'd1;
            if (val_left == 16'd0) begin
               res.attr_done = 1'b1;
               res.packet_done = close_segment();
            end
         end
         ST_SKIP: begin
            pkt_left = pkt_left - 16'd1;
            if (pkt_left == 16'd0) begin
               res.packet_done = 1'b1;
               pstate = ST_IDLE;
            end
         end
         default: pstate = ST_IDLE;
      endcase
      res.application_id = cur_app;
      res.packet_code    = cur_code;
      res.packet_length  = cur_plen;
      res.attr_type      = cur_atype;
      res.attr_length    = cur_alen;
      res.parse_error    = err_flag;
      return res;
   endfunction

   function automatic string show_result(rsp_type r);
      return $sformatf({"cls=%0d app=%h code=%h plen=%h atype=%h alen=%h ",
                        "val=%h vidx=%h adone=%b pdone=%b err=%0d"},
                       r.byte_class, r.application_id, r.packet_code, r.packet_length,
                       r.attr_type, r.attr_length, r.value_byte, r.value_index,
                       r.attr_done, r.packet_done, r.parse_error);
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned pick_gap(bit gappy);
      int unsigned roll;
      if (!gappy)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void push_byte(logic [7:0] d, logic s);
      frame_q.push_back(req_type'{data_byte: d, frame_start: s});
   endfunction

   // builds one stream segment in frame_q; returns 0 for stray bytes outside a packet
   function automatic bit build_frame();
      int unsigned kind, n_attr, vlen, bad_attr, cut;
      logic [15:0] plen, alen;
      logic [7:0]  body[$];
      frame_q.delete();
      kind = $urandom_range(0, 19);
      if (kind == 19) begin
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
         return 1'b0;
      end
      n_attr = $urandom_range(0, 4);
      bad_attr = (n_attr == 0) ? 0 : $urandom_range(0, n_attr - 1);
      for (int a = 0; a < n_attr; a++) begin
         vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
         alen = 16'(vlen + 3);
         if (kind == 15 && a == bad_attr)
            alen = 16'($urandom_range(0, 2));
         if (kind == 16 && a == bad_attr)
            alen = alen + 16'($urandom_range(1, 12));
         body.push_back(8'($urandom));
         body.push_back(alen[15:8]);
         body.push_back(alen[7:0]);
         repeat (vlen) body.push_back(8'($urandom));
      end
      plen = 16'(body.size() + 5);
      if (kind == 17) begin
         case ($urandom_range(0, 2))
            0: plen = 16'($urandom_range(0, 4));
            1: plen = plen - 16'd3 + 16'($urandom_range(0, 6));
            default: plen = 16'($urandom);
         endcase
      end
      push_byte(8'($urandom), 1'b1);
      push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b0);
      push_byte(plen[15:8], 1'b0);
      push_byte(plen[7:0], 1'b0);
      foreach (body[i]) push_byte(body[i], 1'b0);
      // cut short: the next frame start restarts the parser mid-packet
      if (kind == 18) begin
         cut = $urandom_range(1, frame_q.size() - 1);
         repeat (cut) void'(frame_q.pop_back());
      end
      return 1'b1;
   endfunction

   task automatic send_byte(req_type item, logic pinned, logic [2:0] cls, logic [1:0] err,
                            logic done);
      int unsigned gap;
      rsp_type     want;
      gap = pick_gap(sender_gappy);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      want = classify_byte(item);
      if (pinned) begin
         want.byte_class  = cls;
         want.parse_error = err;
         want.packet_done = done;
      end
      classified_q.push_back(want);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (classified_q.size() != 0);
   endtask

   initial begin : stimulus
      int unsigned sent, next_drain;
      bit          counted;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (script[i])
         send_byte(script[i].item, script[i].pinned, script[i].cls, script[i].err,
                   script[i].done);
      drain_results();
      sent = 0;
      next_drain = DRAIN_EVERY;
      while (sent < RANDOM_ITEMS) begin
         counted = build_frame();
         if ($urandom_range(0, 4) == 0)
            sender_gappy = !sender_gappy;
         foreach (frame_q[i])
            send_byte(frame_q[i], 1'b0, CLS_IGNORE, ERR_NONE, 1'b0);
         if (counted)
            sent += frame_q.size();
         if (sent >= next_drain) begin
            drain_results();
            next_drain += DRAIN_EVERY;
         end
      end
      drain_results();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // receiver: runs of choppy stalling and stretches of none follow in random order
   initial begin : rsp_side
      int unsigned hold, burst_left;
      bit          choppy;
      burst_left = 0;
      choppy = 1'b0;
      forever begin
         @(posedge clock);
         if (burst_left == 0) begin
            choppy = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(50, 300);
         end
         burst_left--;
         if (choppy && $urandom_range(0, 99) < 25) begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (classified_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result with nothing outstanding: %s", show_result(rsp_payload));
         end else begin
            oldest = classified_q.pop_front();
            if (rsp_payload.byte_class     !== oldest.byte_class     ||
                rsp_payload.application_id !== oldest.application_id ||
                rsp_payload.packet_code    !== oldest.packet_code    ||
                rsp_payload.packet_length  !== oldest.packet_length  ||
                rsp_payload.attr_type      !== oldest.attr_type      ||
                rsp_payload.attr_length    !== oldest.attr_length    ||
                rsp_payload.value_byte     !== oldest.value_byte     ||
                rsp_payload.value_index    !== oldest.value_index    ||
                rsp_payload.attr_done      !== oldest.attr_done      ||
                rsp_payload.packet_done    !== oldest.packet_done    ||
                rsp_payload.parse_error    !== oldest.parse_error) begin
               failures++;
               if (failures <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  expected %s", show_result(oldest));
                  $display("  actual   %s", show_result(rsp_payload));
               end
            end
         end
      end
   end

   // watchdog: no transfer on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer in %0d cycles, %0d results outstanding",
                     idle_cycles, classified_q.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/tlvd_pkg.sv
rtl/tlvd_front.sv
rtl/tlvd_queue.sv
rtl/tlvd_back.sv
rtl/tlv_packet_deframer_core.sv
verif/tlv_packet_deframer_core_test.sv
